/* rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants
// Item types for the byte and code-unit channels, the unit bundle passed from
// the decoder to the output queue, and the UTF-16 constants.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	// UTF-16 constants
	localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
	localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
	localparam logic [20:0] SUPPLEMENT_BASE  = 21'h10000;

	// Most code units one byte can produce
	localparam int unsigned MAX_UNITS = 4;

	// Default output queue depth (power of two, at least MAX_UNITS)
	localparam int unsigned FIFO_DEPTH = 8;

	// Input item: one UTF-8 byte
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} u8_item_t;

	// Result item: one UTF-16 code unit
	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
	} u16_item_t;

	// All units caused by one byte, unit 0 first
	typedef struct packed {
		logic [2:0]                 count;
		logic [MAX_UNITS-1:0][15:0] units;
	} unit_bundle_t;

endpackage

/* rtl/u8u16_decode.sv */
// ----------------------------------------------------------------------------
// u8u16_decode: sequence state and per-byte decode
// Holds the pending sequence and turns the registered byte into a bundle of
// zero to four code units in one combinational pass.
// ----------------------------------------------------------------------------
module u8u16_decode import u8u16_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  u8_item_t     item,
	output unit_bundle_t bundle
);

	logic [2:0]  needed_q;
	logic [1:0]  taken_q;
	logic [20:0] partial_q;
	logic [2:0]  needed_d;
	logic [1:0]  taken_d;
	logic [20:0] partial_d;

	logic [7:0]  b;
	logic        last;
	logic        is_cont;

	logic        lead_emit;
	logic        lead_open;
	logic [15:0] lead_unit;
	logic [2:0]  lead_len;
	logic [20:0] lead_bits;

	logic [20:0] cont_partial;
	logic [2:0]  taken_inc;
	logic        cont_done;
	logic        is_supp;
	logic [20:0] supp_off;
	logic [15:0] high_unit;
	logic [15:0] low_unit;
	logic [2:0]  still;
	logic [2:0]  reps;

	logic [15:0] units [MAX_UNITS];
	logic [2:0]  count;

	assign b       = item.in_byte;
	assign last    = item.end_of_input;
	assign is_cont = (b[7:6] == 2'b10);

	// Classify the byte as if it starts a new sequence
	always_comb begin
		lead_emit = 1'b0;
		lead_open = 1'b0;
		lead_unit = REPLACEMENT_UNIT;
		lead_len  = 3'd0;
		lead_bits = '0;
		priority if (!b[7]) begin
			lead_emit = 1'b1;
			lead_unit = {8'h00, b};
		end else if (b[7:5] == 3'b110) begin
			lead_len  = 3'd2;
			lead_bits = {16'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			lead_len  = 3'd3;
			lead_bits = {17'd0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			lead_len  = 3'd4;
			lead_bits = {18'd0, b[2:0]};
		end else begin
			// stray continuation or 11111xxx
			lead_emit = 1'b1;
		end
		// a sequence opened on the final byte cannot finish
		if (lead_len != 3'd0) begin
			if (last) begin
				lead_emit = 1'b1;
			end else begin
				lead_open = 1'b1;
			end
		end
	end

	// Extend the pending code point and split it into surrogates
	assign cont_partial = {partial_q[14:0], b[5:0]};
	assign taken_inc    = {1'b0, taken_q} + 3'd1;
	assign cont_done    = (taken_inc + 3'd1) >= needed_q;
	assign is_supp      = cont_partial >= SUPPLEMENT_BASE;
	assign supp_off     = cont_partial - SUPPLEMENT_BASE;
	assign high_unit    = HIGH_SURR_BASE + {5'd0, supp_off[20:10]};
	assign low_unit     = LOW_SURR_BASE | {6'd0, supp_off[9:0]};
	assign still        = needed_q - 3'd1 - {1'b0, taken_q};
	assign reps         = {1'b0, taken_q} + 3'd1;

	// Build the unit bundle and the next sequence state
	always_comb begin
		for (int k = 0; k < MAX_UNITS; k++) begin
			units[k] = REPLACEMENT_UNIT;
		end
		count     = 3'd0;
		needed_d  = needed_q;
		taken_d   = taken_q;
		partial_d = partial_q;
		priority if (needed_q == 3'd0) begin
			units[0] = lead_unit;
			count    = {2'b00, lead_emit};
			if (lead_open) begin
				needed_d  = lead_len;
				taken_d   = 2'd0;
				partial_d = lead_bits;
			end
		end else if (is_cont) begin
			if (cont_done) begin
				needed_d  = 3'd0;
				taken_d   = 2'd0;
				partial_d = '0;
				if (is_supp) begin
					units[0] = high_unit;
					units[1] = low_unit;
					count    = 3'd2;
				end else begin
					units[0] = cont_partial[15:0];
					count    = 3'd1;
				end
			end else if (last) begin
				needed_d  = 3'd0;
				taken_d   = 2'd0;
				partial_d = '0;
				count     = 3'd1;
			end else begin
				partial_d = cont_partial;
				taken_d   = taken_inc[1:0];
			end
		end else begin
			// broken sequence: drop the pending state
			needed_d  = 3'd0;
			taken_d   = 2'd0;
			partial_d = '0;
			if (last && (still > 3'd1)) begin
				count = 3'd1;
			end else begin
				units[reps[1:0]] = lead_unit;
				count            = reps + {2'b00, lead_emit};
				if (lead_open) begin
					needed_d  = lead_len;
					partial_d = lead_bits;
				end
			end
		end
	end

	// Pack the bundle
	always_comb begin
		bundle.count = count;
		for (int k = 0; k < MAX_UNITS; k++) begin
			bundle.units[k] = units[k];
		end
	end

	// Advance the sequence state once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q  <= 3'd0;
			taken_q   <= 2'd0;
			partial_q <= '0;
		end else if (advance) begin
			needed_q  <= needed_d;
			taken_q   <= taken_d;
			partial_q <= partial_d;
		end
	end

endmodule

/* rtl/u8u16_unit_fifo.sv */
// ----------------------------------------------------------------------------
// u8u16_unit_fifo: code-unit output queue
// Takes a whole bundle of up to four units at once and hands them out one
// per transfer; marks the final unit of each bundle.
// ----------------------------------------------------------------------------
module u8u16_unit_fifo import u8u16_pkg::*; #(
	parameter  int unsigned DEPTH = FIFO_DEPTH,
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  unit_bundle_t     push_bundle,
	input  logic             pop,
	output logic             head_valid,
	output u16_item_t        head,
	output logic [CNT_W-1:0] level
);

	localparam int unsigned PTR_W = $clog2(DEPTH);

	u16_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] level_q;
	logic [2:0]       push_cnt;

	assign push_cnt   = push ? push_bundle.count : 3'd0;
	assign head_valid = (level_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign level      = level_q;

	// Write the bundle's units at consecutive slots
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_UNITS; k++) begin
			if (3'(k) < push_cnt) begin
				mem_q[wr_ptr_q + PTR_W'(k)] <= '{
					code_unit: push_bundle.units[k],
					last_unit: (3'(k) == (push_cnt - 3'd1))
				};
			end
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			level_q <= level_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

endmodule

/* rtl/utf8_to_utf16_transcoder_top.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top: UTF-8 byte stream to UTF-16 code units
// Path: a byte is held in the input register, decoded into the output queue once the queue has room, then offered.
// Throughput: one byte per cycle while the queue has room for 4 units; one unit out per cycle while utf16_stall is low.
// Reset: arst_n clears the pending sequence and empties the output queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top import u8u16_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      utf8_valid,
	output logic      utf8_stall,
	input  u8_item_t  utf8_data,
	output logic      utf16_valid,
	input  logic      utf16_stall,
	output u16_item_t utf16_data
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic             valid_s1;
	u8_item_t         item_s1;
	logic             accept;
	logic             advance;
	logic             room;
	logic [CNT_W-1:0] level;
	unit_bundle_t     bundle;

	// Process the held byte only when the queue can take a full bundle
	assign room       = level <= CNT_W'(DEPTH - MAX_UNITS);
	assign advance    = valid_s1 && room;
	assign utf8_stall = valid_s1 && !room;
	assign accept     = utf8_valid && !utf8_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= utf8_data;
		end
	end

	u8u16_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.bundle  (bundle)
	);

	u8u16_unit_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (advance),
		.push_bundle (bundle),
		.pop         (utf16_valid && !utf16_stall),
		.head_valid  (utf16_valid),
		.head        (utf16_data),
		.level       (level)
	);

`ifndef NO_ASSERTIONS
	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		level <= CNT_W'(DEPTH))
		else $error("output queue overfilled");

	// a byte never produces more units than a bundle holds
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (bundle.count <= 3'(MAX_UNITS)))
		else $error("bundle count out of range");

	// the final byte of a string always closes with at least one unit
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.end_of_input) |-> (bundle.count != 3'd0))
		else $error("final byte produced no unit");

	// a processed byte with units shows output valid in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (bundle.count != 3'd0)) |=> utf16_valid)
		else $error("pushed units not visible at output");
`endif

endmodule

/* tb/sv/utf8_to_utf16_transcoder_top_tb.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top_tb: self-checking bench for the UTF-8 to UTF-16
// transcoder.
// A directed byte string covers ASCII, every sequence length, surrogate pairs,
// stray bytes, broken and truncated sequences. Random strings follow, mostly
// well-formed characters with random content, plus noise. Each phase uses a
// different mix of sender gaps and receiver stalls. A scoreboard predicts the
// code units of every byte transfer and checks each unit transfer in order.
// ----------------------------------------------------------------------------

// Predicts the code units of each accepted byte and checks the units received
class utf16_scoreboard;
	// Decoder state
	logic [2:0]  seq_len    = '0;
	logic [1:0]  cont_count = '0;
	logic [20:0] cp_acc     = '0;

	// Units of the current byte, then all units still awaited
	logic [15:0]              step_units[$];
	u8u16_pkg::u16_item_t     awaited_units[$];

	int errors        = 0;
	int units_checked = 0;

	task report_mismatch(input string msg);
		$display("mismatch at unit %0d: %s", units_checked, msg);
		errors++;
	endtask

	function void clear_sequence();
		seq_len    = '0;
		cont_count = '0;
		cp_acc     = '0;
	endfunction

	function void add_unit(input logic [15:0] unit);
		step_units = {step_units, unit};
	endfunction

	// Handle a byte with no sequence pending
	function void open_sequence(input logic [7:0] b, input bit eoi);
		logic [2:0]  len;
		logic [20:0] payload;
		payload = '0;
		casez (b)
			8'b0???????: len = 3'd1;
			8'b110?????: begin
				len = 3'd2;
				payload = {16'd0, b[4:0]};
			end
			8'b1110????: begin
				len = 3'd3;
				payload = {17'd0, b[3:0]};
			end
			8'b11110???: begin
				len = 3'd4;
				payload = {18'd0, b[2:0]};
			end
			default: len = 3'd0;
		endcase
		if (len == 3'd1)
			add_unit({8'h00, b});
		else if (len == 3'd0 || eoi)
			add_unit(u8u16_pkg::REPLACEMENT_UNIT);
		else begin
			seq_len    = len;
			cont_count = '0;
			cp_acc     = payload;
		end
	endfunction

	// Note a byte transfer and queue the units it should cause
	function void take_byte(input u8u16_pkg::u8_item_t item);
		logic [7:0]  b;
		logic [20:0] offset;
		logic [15:0] hi_unit;
		logic [15:0] lo_unit;
		bit          eoi;
		int          remaining;
		int          reps;
		u8u16_pkg::u16_item_t unit_item;
		b   = item.in_byte;
		eoi = item.end_of_input;
		step_units.delete();
		if (seq_len == 3'd0)
			open_sequence(b, eoi);
		else if (b[7:6] == 2'b10) begin
			// Gather six more bits; finish or give up at end of string
			cp_acc     = {cp_acc[14:0], b[5:0]};
			cont_count = cont_count + 2'd1;
			if (int'(cont_count) + 1 >= int'(seq_len)) begin
				if (cp_acc >= u8u16_pkg::SUPPLEMENT_BASE) begin
					offset  = cp_acc - u8u16_pkg::SUPPLEMENT_BASE;
					hi_unit = u8u16_pkg::HIGH_SURR_BASE + {5'd0, offset[20:10]};
					lo_unit = u8u16_pkg::LOW_SURR_BASE + {6'd0, offset[9:0]};
					add_unit(hi_unit);
					add_unit(lo_unit);
				end else
					add_unit(cp_acc[15:0]);
				clear_sequence();
			end else if (eoi) begin
				clear_sequence();
				add_unit(u8u16_pkg::REPLACEMENT_UNIT);
			end
		end else begin
			// Broken sequence, or one truncated by the end of the string
			remaining = int'(seq_len) - 1 - int'(cont_count);
			if (eoi && remaining > 1) begin
				clear_sequence();
				add_unit(u8u16_pkg::REPLACEMENT_UNIT);
			end else begin
				reps = 1 + int'(cont_count);
				clear_sequence();
				repeat (reps) add_unit(u8u16_pkg::REPLACEMENT_UNIT);
				open_sequence(b, eoi);
			end
		end
		foreach (step_units[i]) begin
			unit_item.code_unit = step_units[i];
			unit_item.last_unit = (i == step_units.size() - 1);
			awaited_units = {awaited_units, unit_item};
		end
	endfunction

	// Compare one unit transfer with the oldest awaited unit
	task check_unit(input u8u16_pkg::u16_item_t got);
		u8u16_pkg::u16_item_t want;
		if (awaited_units.size() == 0)
			report_mismatch($sformatf("unexpected unit %h last %b",
				got.code_unit, got.last_unit));
		else begin
			want = awaited_units.pop_front();
			if (got.code_unit !== want.code_unit)
				report_mismatch($sformatf("code_unit %h, want %h",
					got.code_unit, want.code_unit));
			if (got.last_unit !== want.last_unit)
				report_mismatch($sformatf("last_unit %b, want %b (unit %h)",
					got.last_unit, want.last_unit, want.code_unit));
		end
		units_checked++;
	endtask

	function int pending();
		return awaited_units.size();
	endfunction
endclass

module utf8_to_utf16_transcoder_top_tb;
	import u8u16_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_TAIL  = 6;
	localparam int HOLD_CYCLES = 300;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      utf8_valid  = 1'b0;
	logic      utf8_stall;
	u8_item_t  utf8_data   = '0;
	logic      utf16_valid;
	logic      utf16_stall = 1'b0;
	u16_item_t utf16_data;

	utf16_scoreboard unit_ledger = new;

	u8_item_t byte_q[$];
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_left      = 0;
	int cycle_count    = 0;

	utf8_to_utf16_transcoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.utf8_valid  (utf8_valid),
		.utf8_stall  (utf8_stall),
		.utf8_data   (utf8_data),
		.utf16_valid (utf16_valid),
		.utf16_stall (utf16_stall),
		.utf16_data  (utf16_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check each unit transfer; hold off or stall at random
	always @(posedge clk) begin
		if (arst_n && utf16_valid && !utf16_stall)
			unit_ledger.check_unit(utf16_data);
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			utf16_stall <= 1'b1;
			hold_left--;
		end else
			utf16_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// End the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("utf8_to_utf16_transcoder_top_tb NOT OK");
		$finish;
	end

	task automatic queue_byte(input logic [7:0] b, input bit eoi);
		u8_item_t item;
		item.in_byte      = b;
		item.end_of_input = eoi;
		byte_q = {byte_q, item};
	endtask

	// Fill the byte queue with random characters, noise and broken sequences
	task automatic build_stream(input int n_bytes);
		int          kind;
		int          len;
		int          n_cont;
		bit          end_here;
		logic [31:0] r;
		logic [7:0]  lead;
		logic [7:0]  b;
		while (byte_q.size() < n_bytes) begin
			kind = $urandom_range(99);
			len  = $urandom_range(4, 1);
			r    = $urandom;
			case (len)
				1:       lead = {1'b0, r[6:0]};
				2:       lead = {3'b110, r[4:0]};
				3:       lead = {4'b1110, r[3:0]};
				default: lead = {5'b11110, r[2:0]};
			endcase
			if (kind < 15) begin
				// noise byte
				queue_byte(r[15:8], $urandom_range(99) < 30);
			end else begin
				if (kind < 80 || len == 1) begin
					n_cont   = len - 1;
					end_here = ($urandom_range(99) < 8);
				end else begin
					n_cont   = $urandom_range(len - 2, 0);
					end_here = 1'($urandom_range(1));
				end
				for (int k = 0; k <= n_cont; k++) begin
					r = $urandom;
					b = (k == 0) ? lead : {2'b10, r[5:0]};
					queue_byte(b, (k == n_cont) && end_here);
				end
				// break a short sequence with a non-continuation byte
				if (n_cont < len - 1 && !end_here) begin
					r = $urandom;
					b = r[7:0];
					if (b[7:6] == 2'b10)
						b[6] = 1'b1;
					queue_byte(b, $urandom_range(99) < 20);
				end
			end
		end
	endtask

	// Offer every queued byte; note each one at its transfer
	task automatic send_all();
		u8_item_t item;
		while (byte_q.size() > 0) begin
			item = byte_q.pop_front();
			if ($urandom_range(99) < send_idle_pct) begin
				utf8_valid <= 1'b0;
				@(posedge clk);
				while ($urandom_range(99) < send_idle_pct) @(posedge clk);
			end
			utf8_valid <= 1'b1;
			utf8_data  <= item;
			@(posedge clk);
			while (utf8_stall) @(posedge clk);
			unit_ledger.take_byte(item);
		end
		utf8_valid <= 1'b0;
	endtask

	// Wait for every awaited unit, then wait out DRAIN_TAIL
	task automatic wait_drain();
		while (unit_ledger.pending() > 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic run_phase(input int n_bytes, input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		build_stream(n_bytes);
		send_all();
		wait_drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed string
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'hC3, 1'b0);   // two-byte character
		queue_byte(8'hA9, 1'b0);
		queue_byte(8'hE2, 1'b0);   // three-byte character
		queue_byte(8'h82, 1'b0);
		queue_byte(8'hAC, 1'b0);
		queue_byte(8'hF0, 1'b0);   // four-byte character, surrogate pair
		queue_byte(8'h9F, 1'b0);
		queue_byte(8'h98, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h80, 1'b0);   // stray continuation
		queue_byte(8'hFF, 1'b0);   // invalid lead
		queue_byte(8'hF7, 1'b0);   // largest value a four-byte lead can build
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hF0, 1'b0);   // broken after two continuations
		queue_byte(8'h90, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h41, 1'b0);
		queue_byte(8'hE2, 1'b1);   // lead on the final byte
		queue_byte(8'hE2, 1'b0);   // truncated by end on a continuation
		queue_byte(8'h82, 1'b1);
		queue_byte(8'hF0, 1'b0);   // truncated by end on a non-continuation
		queue_byte(8'hC3, 1'b1);
		queue_byte(8'hC3, 1'b0);   // broken by the final byte
		queue_byte(8'h41, 1'b1);
		send_all();
		wait_drain();

		// Random strings under each idling mix
		run_phase(100, 0, 0);
		run_phase(100, 71, 0);
		run_phase(100, 0, 71);
		run_phase(100, 7, 7);

		// Hold the receiver off while the sender keeps offering bytes
		hold_req = HOLD_CYCLES;
		run_phase(50, 0, 0);

		if (unit_ledger.pending() != 0)
			unit_ledger.report_mismatch($sformatf("%0d units never arrived",
				unit_ledger.pending()));
		if (unit_ledger.errors == 0)
			$display("utf8_to_utf16_transcoder_top_tb OK");
		else
			$display("utf8_to_utf16_transcoder_top_tb NOT OK");
		$finish;
	end

endmodule
